[sv/led_progress_bar_renderer_assert.svh]
// Assertion shorthands used by the RTL file that carries checks.
`ifndef LED_PROGRESS_BAR_RENDERER_ASSERT_SVH
`define LED_PROGRESS_BAR_RENDERER_ASSERT_SVH

// Checked only while out of reset.
`define LPBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define LPBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/lpbr_pkg.sv]
`default_nettype none

package lpbr_pkg;

  localparam int unsigned MaxLeds    = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ProgW      = 10;
  localparam int unsigned Thousand   = 1000;
  localparam logic [ProgW-1:0] ProgFull = ProgW'(Thousand);
  localparam int unsigned NumW       = 14;
  localparam int unsigned FracW      = 10;
  localparam int unsigned ProdW      = 18;
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] RecipK = 13'd4194;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages  = ProgW / DivBitsPerStage;
  localparam int unsigned NumThemes  = 3;
  localparam int unsigned NumKinds   = 3;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgPaletteSelect = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgLedCount      = 4'd1;

  typedef enum logic [1:0] {
    KindFocus     = 2'd0,
    KindBreak     = 2'd1,
    KindCelebrate = 2'd2
  } color_kind_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Three colors per theme: focus, break, celebrate.
  localparam logic [23:0] ThemeRgb [NumThemes*NumKinds] = '{
    24'hFF5B45, 24'h2DD4BF, 24'hFF9650,
    24'hFF4757, 24'h2ED573, 24'hFFE066,
    24'hC8783C, 24'h8A7D6B, 24'hF0C878
  };

  // The theme index must already be folded into the valid range.
  function automatic rgb_t theme_color(logic [1:0] pal, color_kind_e kind);
    logic [3:0] idx;
    idx = 4'(pal) * 4'(NumKinds) + 4'(kind);
    return rgb_t'(ThemeRgb[idx]);
  endfunction

  typedef struct packed {
    logic              idle;
    logic              alarm;
    logic              brk;
    logic              paused;
    logic              zero_tot;
    logic              over;
    logic [CountW-1:0] n;
    logic [1:0]        pal;
    logic [TimeW-1:0]  divisor;
    logic [TimeW-1:0]  part;
    logic [ProgW-1:0]  low;
    logic [ProgW-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [CountW-1:0] n;
    logic [CountW-1:0] full;
    logic              lead;
    rgb_t              lit;
    rgb_t              dim;
  } frame_t;

endpackage

`default_nettype wire

[sv/lpbr_div_stage.sv]
`default_nettype none

module lpbr_div_stage import lpbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  div_t           data_d;
  div_t           data_q;
  logic           valid_q;
  logic [TimeW:0] trial;
  logic [TimeW:0] diff;

  // Restoring division, two quotient bits per stage. The partial remainder
  // stays below the divisor, so one compare and subtract settles each bit.
  always_comb begin
    data_d = data_i;
    trial  = '0;
    diff   = '0;
    for (int k = 0; k < DivBitsPerStage; k++) begin
      trial      = {data_d.part, data_d.low[ProgW-1]};
      data_d.low = data_d.low << 1;
      diff       = trial - {1'b0, data_d.divisor};
      if (trial >= {1'b0, data_d.divisor}) begin
        data_d.part = diff[TimeW-1:0];
        data_d.quo  = {data_d.quo[ProgW-2:0], 1'b1};
      end else begin
        data_d.part = trial[TimeW-1:0];
        data_d.quo  = {data_d.quo[ProgW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[sv/lpbr_emit.sv]
`default_nettype none

module lpbr_emit import lpbr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            frame_valid_i,
  input  frame_t          frame_i,
  output logic            frame_take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdxW-1:0] led_index_o,
  output logic [7:0]      led_red_o,
  output logic [7:0]      led_green_o,
  output logic [7:0]      led_blue_o,
  output logic            last_led_o
);

  logic              busy_d, busy_q;
  frame_t            frame_q;
  logic [IdxW-1:0]   idx_d, idx_q;
  logic              out_valid_d, out_valid_q;
  logic [IdxW-1:0]   index_q;
  rgb_t              color_d, color_q;
  logic              last_q;
  logic              out_load;
  logic              cur_last;
  logic [CountW-1:0] pos;

  assign pos      = CountW'(idx_q);
  assign out_load = busy_q && (!out_valid_q || out_ready_i);
  assign cur_last = (pos == frame_q.n - CountW'(1));

  // The next frame is taken in the cycle its predecessor's last LED moves
  // into the output register, so frames follow without a gap.
  assign frame_take_o = !busy_q || (out_load && cur_last);

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + IdxW'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (frame_take_o) begin
      busy_d = frame_valid_i;
      idx_d  = '0;
    end
  end

  always_comb begin
    color_d = '0;
    if (pos < frame_q.full) begin
      color_d = frame_q.lit;
    end else if (pos == frame_q.full && frame_q.lead) begin
      color_d = frame_q.dim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      frame_q <= frame_i;
    end
    if (out_load) begin
      index_q <= idx_q;
      color_q <= color_d;
      last_q  <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = index_q;
  assign led_red_o   = color_q.r;
  assign led_green_o = color_q.g;
  assign led_blue_o  = color_q.b;
  assign last_led_o  = last_q;

endmodule

`default_nettype wire

[sv/led_progress_bar_renderer.sv]
// Path: the first LED of a snapshot reaches the output register after the
// snapshot passes the 13 pipeline stages and the emitter's frame register.
// Throughput: one LED per cycle while out_ready_i is high; the 13-stage pipeline
// takes a new snapshot every cycle while the emitter does not stall its tail.
// Reset: asynchronous and active low; palette 0, 16 LEDs, pipeline empty.
`default_nettype none
`include "led_progress_bar_renderer_assert.svh"

module led_progress_bar_renderer import lpbr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                is_idle_i,
  input  logic                alarm_on_i,
  input  logic                break_active_i,
  input  logic                is_paused_i,
  input  logic [TimeW-1:0]    session_total_ms_i,
  input  logic [TimeW-1:0]    session_remaining_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IdxW-1:0]     led_index_o,
  output logic [7:0]          led_red_o,
  output logic [7:0]          led_green_o,
  output logic [7:0]          led_blue_o,
  output logic                last_led_o
);

  typedef struct packed {
    logic              idle;
    logic              alarm;
    logic [CountW-1:0] n;
    logic [NumW-1:0]   num;
    logic [CountW-1:0] est;
    logic [CountW-1:0] full;
    logic [FracW-1:0]  frac;
    rgb_t              lit;
    logic [ProdW-1:0]  pr;
    logic [ProdW-1:0]  pg;
    logic [ProdW-1:0]  pb;
    rgb_t              dim;
  } tail_t;

  // Estimate of p / 1000 that is low by at most one.
  function automatic logic [7:0] div1000_est(logic [ProdW-1:0] p);
    logic [ProdW+RecipW-1:0] prod;
    prod = (ProdW+RecipW)'(p) * (ProdW+RecipW)'(RecipK);
    return prod[RecipShift +: 8];
  endfunction

  function automatic logic [7:0] div1000_fix(logic [ProdW-1:0] p, logic [7:0] e);
    logic [ProdW-1:0] rest;
    rest = p - ProdW'(e) * ProdW'(Thousand);
    return (rest >= ProdW'(Thousand)) ? e + 8'd1 : e;
  endfunction

  // Configuration registers.
  logic [1:0]        palette_d, palette_q;
  logic [CountW-1:0] count_d, count_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    palette_d = palette_q;
    count_d   = count_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPaletteSelect: palette_d = cfg_data_i[1:0];
        CfgLedCount:      count_d   = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
      count_q   <= CountW'(MaxLeds);
    end else begin
      palette_q <= palette_d;
      count_q   <= count_d;
    end
  end

  // Global stall: the whole pipeline moves when its tail can hand over.
  logic   adv;
  logic   frame_take;
  logic   v0_q, v1_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q;
  div_t   s0_d, s0_q, s1_d, s1_q;
  div_t   dv  [DivStages+1];
  logic   dvv [DivStages+1];
  tail_t  t7_d, t7_q, t8_d, t8_q, t9_d, t9_q;
  tail_t  t10_d, t10_q, t11_d, t11_q, t12_d, t12_q;
  frame_t frame;

  assign adv        = !v12_q || frame_take;
  assign in_ready_o = adv;

  logic [CountW-1:0] n_sat;
  logic              v0_d;

  assign n_sat = (count_q > CountW'(MaxLeds)) ? CountW'(MaxLeds) : count_q;
  // A strip without LEDs yields nothing, so the snapshot is dropped here.
  assign v0_d  = in_valid_i && (n_sat != '0);

  always_comb begin
    s0_d          = '0;
    s0_d.idle     = is_idle_i;
    s0_d.alarm    = alarm_on_i;
    s0_d.brk      = break_active_i;
    s0_d.paused   = is_paused_i;
    s0_d.zero_tot = (session_total_ms_i == '0);
    s0_d.over     = (session_remaining_ms_i > session_total_ms_i);
    s0_d.n        = n_sat;
    s0_d.pal      = (palette_q >= 2'(NumThemes)) ? 2'd0 : palette_q;
    s0_d.divisor  = session_total_ms_i;
    s0_d.part     = session_total_ms_i - session_remaining_ms_i;
  end

  // Elapsed time times 1000, split into the divider's starting remainder and
  // the numerator bits still to be shifted in.
  logic [TimeW+ProgW-1:0] scaled;

  always_comb begin
    scaled    = (TimeW+ProgW)'(s0_q.part) * (TimeW+ProgW)'(ProgFull);
    s1_d      = s0_q;
    s1_d.part = scaled[TimeW+ProgW-1:ProgW];
    s1_d.low  = scaled[ProgW-1:0];
    s1_d.quo  = '0;
  end

  assign dv[0]  = s1_q;
  assign dvv[0] = v1_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    lpbr_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dvv[g]),
      .data_i  (dv[g]),
      .valid_o (dvv[g+1]),
      .data_o  (dv[g+1])
    );
  end

  div_t             dq;
  logic [ProgW-1:0] prog;
  color_kind_e      kind;
  rgb_t             base;

  assign dq = dv[DivStages];

  always_comb begin
    prog = dq.quo;
    if (dq.zero_tot) begin
      prog = '0;
    end else if (dq.over) begin
      prog = ProgFull;
    end
    kind = dq.brk ? KindBreak : KindFocus;
    if (dq.alarm) begin
      kind = KindCelebrate;
    end
    base = theme_color(dq.pal, kind);
    t7_d       = '0;
    t7_d.idle  = dq.idle;
    t7_d.alarm = dq.alarm;
    t7_d.n     = dq.n;
    t7_d.num   = NumW'(prog) * NumW'(dq.n);
    t7_d.lit   = base;
    if (dq.paused && !dq.alarm) begin
      t7_d.lit.r = base.r >> 1;
      t7_d.lit.g = base.g >> 1;
      t7_d.lit.b = base.b >> 1;
    end
  end

  logic [NumW+RecipW-1:0] est_prod;

  always_comb begin
    est_prod = (NumW+RecipW)'(t7_q.num) * (NumW+RecipW)'(RecipK);
    t8_d     = t7_q;
    t8_d.est = est_prod[RecipShift +: CountW];
  end

  logic [NumW-1:0] rest;

  // Whole LEDs and the leading LED's fraction; idle and alarm override.
  always_comb begin
    rest = t8_q.num - NumW'(t8_q.est) * NumW'(Thousand);
    t9_d = t8_q;
    if (rest >= NumW'(Thousand)) begin
      t9_d.full = t8_q.est + CountW'(1);
      t9_d.frac = FracW'(rest - NumW'(Thousand));
    end else begin
      t9_d.full = t8_q.est;
      t9_d.frac = rest[FracW-1:0];
    end
    if (t9_d.full >= t8_q.n) begin
      t9_d.full = t8_q.n;
      t9_d.frac = '0;
    end
    if (t8_q.idle) begin
      t9_d.full = '0;
      t9_d.frac = '0;
    end else if (t8_q.alarm) begin
      t9_d.full = t8_q.n;
      t9_d.frac = '0;
    end
  end

  always_comb begin
    t10_d    = t9_q;
    t10_d.pr = ProdW'(t9_q.lit.r) * ProdW'(t9_q.frac);
    t10_d.pg = ProdW'(t9_q.lit.g) * ProdW'(t9_q.frac);
    t10_d.pb = ProdW'(t9_q.lit.b) * ProdW'(t9_q.frac);
  end

  always_comb begin
    t11_d       = t10_q;
    t11_d.dim.r = div1000_est(t10_q.pr);
    t11_d.dim.g = div1000_est(t10_q.pg);
    t11_d.dim.b = div1000_est(t10_q.pb);
  end

  always_comb begin
    t12_d       = t11_q;
    t12_d.dim.r = div1000_fix(t11_q.pr, t11_q.dim.r);
    t12_d.dim.g = div1000_fix(t11_q.pg, t11_q.dim.g);
    t12_d.dim.b = div1000_fix(t11_q.pb, t11_q.dim.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (adv) begin
      v0_q  <= v0_d;
      v1_q  <= v0_q;
      v7_q  <= dvv[DivStages];
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q  <= s0_d;
      s1_q  <= s1_d;
      t7_q  <= t7_d;
      t8_q  <= t8_d;
      t9_q  <= t9_d;
      t10_q <= t10_d;
      t11_q <= t11_d;
      t12_q <= t12_d;
    end
  end

  assign frame.n    = t12_q.n;
  assign frame.full = t12_q.full;
  assign frame.lead = (t12_q.frac != '0);
  assign frame.lit  = t12_q.lit;
  assign frame.dim  = t12_q.dim;

  lpbr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (v12_q),
    .frame_i       (frame),
    .frame_take_o  (frame_take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_index_o   (led_index_o),
    .led_red_o     (led_red_o),
    .led_green_o   (led_green_o),
    .led_blue_o    (led_blue_o),
    .last_led_o    (last_led_o)
  );

  logic [7:0] pipe_valid;

  assign pipe_valid = {v0_q, v1_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q};

  `LPBR_ASSERT(a_stall_holds, !in_ready_o |=> $stable(pipe_valid),
    "pipeline moved while stalled")
  `LPBR_ASSERT(a_led_order,
    out_valid_o && out_ready_i && !last_led_o |=>
      out_valid_o && led_index_o == $past(led_index_o) + 4'd1,
    "LED sequence broken inside a frame")
  `LPBR_ASSERT(a_frame_start,
    out_valid_o && out_ready_i && last_led_o |=> !out_valid_o || led_index_o == '0,
    "frame does not start at LED zero")
  // The flops are cleared asynchronously by reset; the check uses the non-overlapping implication.
  `LPBR_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o && !v12_q,
    "output or pipeline valid during reset")

endmodule

`default_nettype wire
